// File: rtl/core/rpsu_pkg.sv
package rpsu_pkg;

   localparam int NUM_WEIGHTS = 1024;
   localparam int ADDR_W      = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

   localparam int IDX_W      = 10;
   localparam int VAL_W      = 32;
   localparam int STEP_W     = 31;
   localparam int FACT_W     = 16;
   localparam int FACT_FRAC  = 14;
   localparam int PROD_W     = STEP_W + FACT_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic [FACT_W-1:0] DEF_INCREASE   = 16'd19661;
   localparam logic [FACT_W-1:0] DEF_DECREASE   = 16'd8192;
   localparam logic [STEP_W-1:0] DEF_MAX_STEP   = 31'h7FFF_FFFF;
   localparam logic [STEP_W-1:0] DEF_MIN_STEP   = 31'd0;
   localparam logic [STEP_W-1:0] DEF_INIT_DELTA = 31'd655;
   localparam logic [STEP_W-1:0] DEF_GRAD_THR   = 31'd0;

   typedef enum logic [1:0] {
      MODE_UPDATE = 2'd0,
      MODE_REJECT = 2'd1,
      MODE_LOAD   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      VAR_RPROP_MINUS  = 2'd0,
      VAR_RPROP_PLUS   = 2'd1,
      VAR_IRPROP_PLUS  = 2'd2,
      VAR_IRPROP_MINUS = 2'd3
   } variant_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VARIANT    = 3'd0,
      CSR_INCREASE   = 3'd1,
      CSR_DECREASE   = 3'd2,
      CSR_MAX_STEP   = 3'd3,
      CSR_MIN_STEP   = 3'd4,
      CSR_INIT_DELTA = 3'd5,
      CSR_GRAD_THR   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_FETCH  = 2'd1,
      ST_SCALE  = 2'd2,
      ST_COMMIT = 2'd3
   } state_type;

   typedef struct packed {
      mode_type                mode;
      logic [IDX_W-1:0]        index;
      logic signed [VAL_W-1:0] weight;
      logic signed [VAL_W-1:0] gradient;
      logic [VAL_W-1:0]        error_now;
      logic                    sweep_end;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        index_out;
      logic signed [VAL_W-1:0] new_weight;
      logic [STEP_W-1:0]       step_out;
   } rsp_type;

   typedef struct packed {
      variant_type       variant;
      logic [FACT_W-1:0] increase_factor;
      logic [FACT_W-1:0] decrease_factor;
      logic [STEP_W-1:0] max_step;
      logic [STEP_W-1:0] min_step;
      logic [STEP_W-1:0] init_delta;
      logic [STEP_W-1:0] grad_threshold;
   } cfg_type;

   typedef struct packed {
      logic [STEP_W-1:0]       step;
      logic signed [VAL_W-1:0] prev_gradient;
      logic signed [VAL_W-1:0] last_move;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic accept;
      logic fetch;
      logic scale;
      logic commit;
   } stage_ctrl_type;

endpackage

// File: rtl/core/rprop_step_size_update_core.sv
// An accepted request is registered and passes through the fetch, scale and
// commit states; rsp_strobe is registered from the commit state.
// Requests are taken one at a time: busy stays high from the accept until the
// entry has been read, its step multiplied and the entry written back.
// Reset: synchronous; returns control to idle, loads the register defaults and
// sets the previous error to all ones. The entry memory is not reset.
// The receiver cannot stall; each response is shown for one cycle.
module rprop_step_size_update_core
   import rpsu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   output logic                  rsp_strobe,
   output rsp_type               rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type      state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   cfg_type        cfg_ff;
   stage_ctrl_type ctrl;
   logic           accept;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      ctrl         = '0;
      busy         = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            ctrl.accept = start;
            if (start) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            ctrl.fetch = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            ctrl.scale = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            ctrl.commit  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.variant         <= VAR_RPROP_MINUS;
         cfg_ff.increase_factor <= DEF_INCREASE;
         cfg_ff.decrease_factor <= DEF_DECREASE;
         cfg_ff.max_step        <= DEF_MAX_STEP;
         cfg_ff.min_step        <= DEF_MIN_STEP;
         cfg_ff.init_delta      <= DEF_INIT_DELTA;
         cfg_ff.grad_threshold  <= DEF_GRAD_THR;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_VARIANT:    cfg_ff.variant         <= variant_type'(csr_wdata[1:0]);
            CSR_INCREASE:   cfg_ff.increase_factor <= csr_wdata[FACT_W-1:0];
            CSR_DECREASE:   cfg_ff.decrease_factor <= csr_wdata[FACT_W-1:0];
            CSR_MAX_STEP:   cfg_ff.max_step        <= csr_wdata[STEP_W-1:0];
            CSR_MIN_STEP:   cfg_ff.min_step        <= csr_wdata[STEP_W-1:0];
            CSR_INIT_DELTA: cfg_ff.init_delta      <= csr_wdata[STEP_W-1:0];
            CSR_GRAD_THR:   cfg_ff.grad_threshold  <= csr_wdata[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rpsu_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .cfg         (cfg_ff),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

   assign rsp_strobe = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_to_fetch: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_FETCH))
      else $error("accepted request did not enter fetch");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("response missing four cycles after request");

   a_strobe_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_COMMIT))
      else $error("response strobe without commit");

   a_one_stage: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.fetch, ctrl.scale, ctrl.commit, accept}))
      else $error("overlapping pipeline stages");
`endif

endmodule

// File: rtl/core/rpsu_ram.sv
module rpsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// File: rtl/core/rpsu_datapath.sv
module rpsu_datapath
   import rpsu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  stage_ctrl_type ctrl,
   input  cfg_type        cfg,
   input  req_type        req_payload,
   output rsp_type        rsp_payload
);

   // request and entry pipeline
   req_type                 req_ff;
   logic                    in_range_ff;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [VAL_W-1:0] g_eff_ff, g_eff_in;
   logic                    dir_pos_ff, dir_pos_in;
   logic                    dir_neg_ff, dir_neg_in;
   logic [STEP_W-1:0]       st_old_ff;
   logic signed [VAL_W-1:0] lm_ff;
   logic [STEP_W-1:0]       st_new_ff, st_new_in;
   logic [VAL_W-1:0]        prev_error_ff;
   rsp_type                 rsp_ff, rsp_in;
   entry_type               wr_entry;
   logic                    wr_en;

   logic [ENTRY_W-1:0]      rd_data;
   entry_type               rd_entry;
   logic [VAL_W-1:0]        g_mag;
   logic                    g_zero, pg_zero;
   logic [FACT_W-1:0]       factor;

   logic [PROD_W-FACT_FRAC-1:0] scaled;
   logic [STEP_W-1:0]       scaled_sat;

   logic signed [VAL_W+1:0] w34, st34, mv34, lm34, sum34;
   logic                    plus_family, backtrack, take_back;
   logic signed [VAL_W-1:0] nw_sat;

   rpsu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_WEIGHTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_ff.index)),
      .wr_data (wr_entry),
      .rd_en   (ctrl.accept),
      .rd_addr (ADDR_W'(req_payload.index)),
      .rd_data (rd_data)
   );

   // fetch: gradient threshold, sign agreement, step times factor
   always_comb begin
      rd_entry = entry_type'(rd_data);
      g_mag    = req_ff.gradient[VAL_W-1] ? (~req_ff.gradient + 32'sd1) : req_ff.gradient;
      g_eff_in = req_ff.gradient;
      if ((cfg.variant == VAR_IRPROP_PLUS) && (g_mag < {1'b0, cfg.grad_threshold})) begin
         g_eff_in = '0;
      end
      g_zero     = (g_eff_in == '0);
      pg_zero    = (rd_entry.prev_gradient == '0);
      dir_pos_in = !g_zero && !pg_zero
                   && (g_eff_in[VAL_W-1] == rd_entry.prev_gradient[VAL_W-1]);
      dir_neg_in = !g_zero && !pg_zero
                   && (g_eff_in[VAL_W-1] != rd_entry.prev_gradient[VAL_W-1]);
      factor     = ((req_ff.mode == MODE_REJECT) || dir_neg_in) ? cfg.decrease_factor
                                                                  : cfg.increase_factor;
      prod_in    = {{FACT_W{1'b0}}, rd_entry.step} * {{STEP_W{1'b0}}, factor};
   end

   // scale: saturate and clamp the new step
   always_comb begin
      scaled     = prod_ff[PROD_W-1:FACT_FRAC];
      scaled_sat = (|scaled[PROD_W-FACT_FRAC-1:STEP_W]) ? '1 : scaled[STEP_W-1:0];
      unique case (req_ff.mode)
         MODE_LOAD: begin
            st_new_in = cfg.init_delta;
         end
         MODE_REJECT: begin
            st_new_in = scaled_sat;
         end
         MODE_UPDATE: begin
            if (dir_pos_ff) begin
               st_new_in = (scaled_sat > cfg.max_step) ? cfg.max_step : scaled_sat;
            end else if (dir_neg_ff) begin
               st_new_in = (scaled_sat < cfg.min_step) ? cfg.min_step : scaled_sat;
            end else begin
               st_new_in = st_old_ff;
            end
         end
         MODE_NONE: begin
            st_new_in = st_old_ff;
         end
         default: begin
            st_new_in = st_old_ff;
         end
      endcase
   end

   // commit: move, weight saturation, write-back
   always_comb begin
      w34   = {{2{req_ff.weight[VAL_W-1]}}, req_ff.weight};
      st34  = {3'b000, st_new_ff};
      lm34  = {{2{lm_ff[VAL_W-1]}}, lm_ff};
      if (g_eff_ff == '0) begin
         mv34 = '0;
      end else if (g_eff_ff[VAL_W-1]) begin
         mv34 = st34;
      end else begin
         mv34 = -st34;
      end
      plus_family = (cfg.variant == VAR_RPROP_PLUS) || (cfg.variant == VAR_IRPROP_PLUS);
      backtrack   = plus_family && dir_neg_ff;
      take_back   = backtrack && ((cfg.variant == VAR_RPROP_PLUS)
                                  || (req_ff.error_now > prev_error_ff));
      if (take_back) begin
         sum34 = w34 - lm34;
      end else if (backtrack) begin
         sum34 = w34;
      end else begin
         sum34 = w34 + mv34;
      end
      if ((sum34[VAL_W+1:VAL_W-1] == 3'b000) || (sum34[VAL_W+1:VAL_W-1] == 3'b111)) begin
         nw_sat = sum34[VAL_W-1:0];
      end else if (sum34[VAL_W+1]) begin
         nw_sat = 32'sh8000_0000;
      end else begin
         nw_sat = 32'sh7FFF_FFFF;
      end

      wr_entry.step          = st_new_ff;
      wr_entry.prev_gradient = g_eff_ff;
      wr_entry.last_move     = lm_ff;
      unique case (req_ff.mode)
         MODE_LOAD: begin
            wr_entry.prev_gradient = '0;
            wr_entry.last_move     = '0;
         end
         MODE_REJECT: begin
            wr_entry.prev_gradient = '0;
         end
         MODE_UPDATE: begin
            if (!plus_family) begin
               if ((cfg.variant == VAR_IRPROP_MINUS) && dir_neg_ff) begin
                  wr_entry.prev_gradient = '0;
               end
            end else if (dir_neg_ff) begin
               wr_entry.prev_gradient = '0;
            end else begin
               wr_entry.last_move = mv34[VAL_W-1:0];
            end
         end
         MODE_NONE: begin
            wr_entry.prev_gradient = g_eff_ff;
         end
         default: begin
            wr_entry.prev_gradient = g_eff_ff;
         end
      endcase
      wr_en = ctrl.commit && in_range_ff && (req_ff.mode != MODE_NONE);

      rsp_in.index_out  = req_ff.index;
      rsp_in.new_weight = (in_range_ff && (req_ff.mode == MODE_UPDATE)) ? nw_sat
                                                                        : req_ff.weight;
      rsp_in.step_out   = in_range_ff ? st_new_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         req_ff      <= req_payload;
         in_range_ff <= (32'(req_payload.index) < NUM_WEIGHTS);
      end
      if (ctrl.fetch) begin
         prod_ff    <= prod_in;
         g_eff_ff   <= g_eff_in;
         dir_pos_ff <= dir_pos_in;
         dir_neg_ff <= dir_neg_in;
         st_old_ff  <= rd_entry.step;
         lm_ff      <= rd_entry.last_move;
      end
      if (ctrl.scale) begin
         st_new_ff <= st_new_in;
      end
      if (ctrl.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '1;
      end else if (ctrl.commit) begin
         if (in_range_ff && (req_ff.mode == MODE_LOAD)) begin
            prev_error_ff <= '1;
         end else if ((req_ff.mode == MODE_UPDATE) && req_ff.sweep_end) begin
            prev_error_ff <= req_ff.error_now;
         end
      end
   end

   assign rsp_payload = rsp_ff;

endmodule
